[src/jitl_pkg.sv]
// jitl_pkg: shared types, constants and helpers of the joint impedance torque law unit.
// No dependencies. Imported by every module in src.
`default_nettype none

package jitl_pkg;

    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 31;
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam int ACC_W      = 64;
    localparam int MUL_STEPS  = GAIN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int JOINT_W    = 3;

    localparam int DEF_NUM_JOINTS = 7;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd64881;
    localparam logic [GAIN_W-1:0]  CGAIN_RESET = 31'd65536;
    localparam logic [GAIN_W-1:0]  STEP_RESET  = 31'd65536;

    localparam logic signed [ACC_W-1:0] S32_MAX64 = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] S32_MIN64 = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ALPHA    = 2'd0,
        CFG_CORIOLIS_GAIN   = 2'd1,
        CFG_MAX_TORQUE_STEP = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_CONTROL = 1'b0,
        OP_LOAD    = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_FILT,
        ST_DIFF,
        ST_CLAMP,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_DECAY,
        PH_SAMPLE,
        PH_CORIOLIS,
        PH_STIFF,
        PH_DAMP
    } t_phase;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] mcand;
        logic [GAIN_W-1:0]        mplier;
    } t_mul_req;

    typedef struct packed {
        logic gain_we;
        logic filt_we;
    } t_store_wr;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [DATA_W-1:0] res;
        if (x > S32_MAX64) begin
            res = S32_MAX64[DATA_W-1:0];
        end else if (x < S32_MIN64) begin
            res = S32_MIN64[DATA_W-1:0];
        end else begin
            res = x[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/joint_impedance_torque_law_unit.sv]
// joint_impedance_torque_law_unit: top level, item sequencer, velocity filter,
// torque accumulation and step limiter. Depends on jitl_pkg, jitl_serial_mult, jitl_joint_store.
//
// channel  direction  handshake                   payload
// in       input      i_in_valid / o_in_stall     i_operation .. i_damping_in
// out      output     o_out_valid / i_out_stall   o_joint_out, o_torque_command, o_was_limited
// cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A control beat runs five products in turn on the single bit-serial multiplier
// (31 multiplier bits, one per cycle) before it gives a valid result.
// Gain loads and beats for absent joints are taken without leaving idle and give no result.
// The next beat is accepted in the cycle after the result is latched, even if out is stalled;
// a second result waits until the output register is free.
// Reset clears the per-joint tables and restores the register defaults.
`default_nettype none

module joint_impedance_torque_law_unit #(
    parameter int NUM_JOINTS = jitl_pkg::DEF_NUM_JOINTS,
    parameter int FRAC_BITS  = jitl_pkg::DEF_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_operation,
    input  logic [jitl_pkg::JOINT_W-1:0]           i_joint,
    input  logic signed [jitl_pkg::DATA_W-1:0]     i_angle_target,
    input  logic signed [jitl_pkg::DATA_W-1:0]     i_angle_measured,
    input  logic signed [jitl_pkg::DATA_W-1:0]     i_speed_target,
    input  logic signed [jitl_pkg::DATA_W-1:0]     i_speed_measured,
    input  logic signed [jitl_pkg::DATA_W-1:0]     i_coriolis_torque,
    input  logic signed [jitl_pkg::DATA_W-1:0]     i_prior_torque,
    input  logic [jitl_pkg::GAIN_W-1:0]            i_stiffness_in,
    input  logic [jitl_pkg::GAIN_W-1:0]            i_damping_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [jitl_pkg::JOINT_W-1:0]           o_joint_out,
    output logic signed [jitl_pkg::DATA_W-1:0]     o_torque_command,
    output logic                                   o_was_limited,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [jitl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [jitl_pkg::GAIN_W-1:0]            i_cfg_data
);
    import jitl_pkg::*;

    localparam int IW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    // configuration
    logic [ALPHA_W-1:0] r_alpha;
    logic [GAIN_W-1:0]  r_cgain;
    logic [GAIN_W-1:0]  r_step;

    // control
    t_state r_state, n_state;
    t_phase r_phase;
    logic   r_out_valid, n_out_valid;

    // item payload
    logic [JOINT_W-1:0]       r_joint;
    logic [IW-1:0]            r_idx;
    logic signed [DATA_W-1:0] r_q_t, r_q_m, r_v_t, r_v_m, r_cor, r_prior;
    logic signed [DATA_W-1:0] r_filt;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_diff;
    logic                     r_lim;
    logic [JOINT_W-1:0]       r_out_joint;
    logic signed [DATA_W-1:0] r_out_torque;
    logic                     r_out_lim;

    // combinational
    logic                     w_in_acc;
    logic                     w_joint_ok;
    logic [7:0]               w_joint_ext;
    logic [IW-1:0]            w_in_idx;
    logic                     w_out_free;
    logic                     w_load_out;
    logic [ALPHA_W-1:0]       w_alpha;
    logic signed [DATA_W-1:0] w_eq, w_ev, w_filt_new;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  w_step;
    logic signed [ACC_W-1:0]  w_cmd;
    logic signed [DATA_W-1:0] w_fin;
    t_mul_req                 w_req;
    logic                     w_mul_done;
    logic signed [ACC_W-1:0]  w_product;
    t_store_wr                w_wr;
    logic [IW-1:0]            w_st_idx;
    logic [GAIN_W-1:0]        w_st_stiff, w_st_damp;
    logic signed [DATA_W-1:0] w_st_filt;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;

    assign w_joint_ext = {5'b0, i_joint};
    assign w_in_idx    = w_joint_ext[IW-1:0];
    assign w_joint_ok  = ({2'b00, i_joint} < 5'(NUM_JOINTS));

    assign w_alpha    = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign w_eq       = sat32(64'(r_q_t) - 64'(r_q_m));
    assign w_ev       = sat32(64'(r_v_t) - 64'(r_filt));
    assign w_filt_new = sat32(r_acc >>> ALPHA_FRAC);
    assign w_term     = (r_phase == PH_DECAY || r_phase == PH_SAMPLE) ? w_product
                                                                      : (w_product >>> FRAC_BITS);
    assign w_step     = $signed({33'b0, r_step});
    assign w_cmd      = 64'(r_prior) + r_diff;
    assign w_fin      = sat32(w_cmd);

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load_out = (r_state == ST_OUT) && w_out_free;

    // multiplier operands by phase
    always_comb begin
        w_req.start = (r_state == ST_MUL_START);
        unique case (r_phase)
            PH_DECAY: begin
                w_req.mcand  = w_st_filt;
                w_req.mplier = GAIN_W'(ALPHA_ONE - w_alpha);
            end
            PH_SAMPLE: begin
                w_req.mcand  = r_v_m;
                w_req.mplier = GAIN_W'(w_alpha);
            end
            PH_CORIOLIS: begin
                w_req.mcand  = r_cor;
                w_req.mplier = r_cgain;
            end
            PH_STIFF: begin
                w_req.mcand  = w_eq;
                w_req.mplier = w_st_stiff;
            end
            PH_DAMP: begin
                w_req.mcand  = w_ev;
                w_req.mplier = w_st_damp;
            end
            default: begin
                w_req.mcand  = '0;
                w_req.mplier = '0;
            end
        endcase
    end

    always_comb begin
        w_wr.gain_we = w_in_acc && w_joint_ok && (i_operation == OP_LOAD);
        w_wr.filt_we = (r_state == ST_FILT);
        w_st_idx     = (r_state == ST_IDLE) ? w_in_idx : r_idx;
    end

    jitl_serial_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    jitl_joint_store #(
        .NUM_JOINTS (NUM_JOINTS),
        .IW         (IW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_wr),
        .i_idx       (w_st_idx),
        .i_stiffness (i_stiffness_in),
        .i_damping   (i_damping_in),
        .i_filt      (w_filt_new),
        .o_stiffness (w_st_stiff),
        .o_damping   (w_st_damp),
        .o_filt      (w_st_filt)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_cgain <= CGAIN_RESET;
            r_step  <= STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FILTER_ALPHA:    r_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_CORIOLIS_GAIN:   r_cgain <= i_cfg_data;
                CFG_MAX_TORQUE_STEP: r_step  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_DECAY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ST_IDLE) begin
                r_phase <= PH_DECAY;
            end else if (r_state == ST_MUL_WAIT && w_mul_done) begin
                unique case (r_phase)
                    PH_DECAY:    r_phase <= PH_SAMPLE;
                    PH_SAMPLE:   r_phase <= PH_CORIOLIS;
                    PH_CORIOLIS: r_phase <= PH_STIFF;
                    PH_STIFF:    r_phase <= PH_DAMP;
                    default:     r_phase <= r_phase;
                endcase
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_joint_ok && i_operation == OP_CONTROL) begin
                    n_state = ST_MUL_START;
                end
            end
            ST_MUL_START: n_state = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (w_mul_done) begin
                    priority case (r_phase)
                        PH_SAMPLE: n_state = ST_FILT;
                        PH_DAMP:   n_state = ST_DIFF;
                        default:   n_state = ST_MUL_START;
                    endcase
                end
            end
            ST_FILT:  n_state = ST_MUL_START;
            ST_DIFF:  n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_joint <= i_joint;
            r_idx   <= w_in_idx;
            r_q_t   <= i_angle_target;
            r_q_m   <= i_angle_measured;
            r_v_t   <= i_speed_target;
            r_v_m   <= i_speed_measured;
            r_cor   <= i_coriolis_torque;
            r_prior <= i_prior_torque;
            r_acc   <= '0;
        end else if (r_state == ST_MUL_WAIT && w_mul_done) begin
            r_acc <= r_acc + w_term;
        end else if (r_state == ST_FILT) begin
            r_filt <= w_filt_new;
            r_acc  <= '0;
        end
        if (r_state == ST_DIFF) begin
            r_diff <= r_acc - 64'(r_prior);
        end else if (r_state == ST_CLAMP) begin
            priority if (r_diff > w_step) begin
                r_diff <= w_step;
                r_lim  <= 1'b1;
            end else if (r_diff < -w_step) begin
                r_diff <= -w_step;
                r_lim  <= 1'b1;
            end else begin
                r_lim <= 1'b0;
            end
        end
        if (w_load_out) begin
            r_out_joint  <= r_joint;
            r_out_torque <= w_fin;
            r_out_lim    <= r_lim || (64'(w_fin) != w_cmd);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_joint_out      = r_out_joint;
    assign o_torque_command = r_out_torque;
    assign o_was_limited    = r_out_lim;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> r_state == ST_MUL_WAIT)
        else $error("multiplier finished outside the wait state");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("result latched without a finished sequence");

    a_diff_after_damp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIFF |-> r_phase == PH_DAMP)
        else $error("limiter entered before all products were summed");

endmodule

`default_nettype wire

[src/jitl_serial_mult.sv]
// jitl_serial_mult: bit-serial shift-add multiplier, signed 32-bit multiplicand times
// unsigned 31-bit multiplier, one multiplier bit per cycle. Depends on jitl_pkg.
`default_nettype none

module jitl_serial_mult (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  jitl_pkg::t_mul_req                    i_req,
    output logic                                  o_done,
    output logic signed [jitl_pkg::ACC_W-1:0]     o_product
);
    import jitl_pkg::*;

    localparam int CNT_W = $clog2(MUL_STEPS);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [DATA_W-1:0] r_mcand;
    logic [GAIN_W-1:0]        r_mp;
    logic signed [DATA_W:0]   r_hi;
    logic [GAIN_W-1:0]        r_lo;

    logic signed [DATA_W+1:0] w_pp;
    logic signed [DATA_W+1:0] w_sum;

    always_comb begin
        w_pp  = r_mp[0] ? {{2{r_mcand[DATA_W-1]}}, r_mcand} : '0;
        w_sum = {r_hi[DATA_W], r_hi} + w_pp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_req.mcand;
            r_mp    <= i_req.mplier;
            r_hi    <= '0;
            r_lo    <= '0;
        end else if (r_busy) begin
            r_hi <= w_sum[DATA_W+1:1];
            r_lo <= {w_sum[0], r_lo[GAIN_W-1:1]};
            r_mp <= r_mp >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

`default_nettype wire

[src/jitl_joint_store.sv]
// jitl_joint_store: per-joint stiffness, damping and filtered velocity registers,
// cleared at reset. Depends on jitl_pkg.
`default_nettype none

module jitl_joint_store #(
    parameter int NUM_JOINTS = jitl_pkg::DEF_NUM_JOINTS,
    parameter int IW         = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  jitl_pkg::t_store_wr                  i_wr,
    input  logic [IW-1:0]                        i_idx,
    input  logic [jitl_pkg::GAIN_W-1:0]          i_stiffness,
    input  logic [jitl_pkg::GAIN_W-1:0]          i_damping,
    input  logic signed [jitl_pkg::DATA_W-1:0]   i_filt,
    output logic [jitl_pkg::GAIN_W-1:0]          o_stiffness,
    output logic [jitl_pkg::GAIN_W-1:0]          o_damping,
    output logic signed [jitl_pkg::DATA_W-1:0]   o_filt
);
    import jitl_pkg::*;

    logic [GAIN_W-1:0]        r_stiff [NUM_JOINTS];
    logic [GAIN_W-1:0]        r_damp  [NUM_JOINTS];
    logic signed [DATA_W-1:0] r_filt  [NUM_JOINTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_JOINTS; i++) begin
                r_stiff[i] <= '0;
                r_damp[i]  <= '0;
                r_filt[i]  <= '0;
            end
        end else begin
            if (i_wr.gain_we) begin
                r_stiff[i_idx] <= i_stiffness;
                r_damp[i_idx]  <= i_damping;
            end
            if (i_wr.filt_we) begin
                r_filt[i_idx] <= i_filt;
            end
        end
    end

    assign o_stiffness = r_stiff[i_idx];
    assign o_damping   = r_damp[i_idx];
    assign o_filt      = r_filt[i_idx];

endmodule

`default_nettype wire

[verif/joint_impedance_torque_law_unit_tb.sv]
// Self-checking testbench for joint_impedance_torque_law_unit: directed and random beats,
// predicted by an in-bench Q16.16 torque law model. Depends on jitl_pkg and the unit's RTL.
`timescale 1ns / 100ps

module joint_impedance_torque_law_unit_tb;
    import jitl_pkg::*;

    localparam int NUM_JOINTS   = 7;
    localparam int FRAC         = 16;
    localparam int SETTLE_CYC   = 220;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SEG_ITEMS    = 220;
    localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic [GAIN_W-1:0] G_MAX = 31'h7FFF_FFFF;

    typedef struct {
        t_op                      op;
        logic [JOINT_W-1:0]       joint;
        logic signed [DATA_W-1:0] angle_target;
        logic signed [DATA_W-1:0] angle_measured;
        logic signed [DATA_W-1:0] speed_target;
        logic signed [DATA_W-1:0] speed_measured;
        logic signed [DATA_W-1:0] coriolis;
        logic signed [DATA_W-1:0] prior;
        logic [GAIN_W-1:0]        stiffness;
        logic [GAIN_W-1:0]        damping;
    } t_beat;

    typedef struct {
        logic [JOINT_W-1:0]       joint;
        logic signed [DATA_W-1:0] torque;
        logic                     limited;
    } t_cmd;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_operation;
    logic [JOINT_W-1:0]       i_joint;
    logic signed [DATA_W-1:0] i_angle_target;
    logic signed [DATA_W-1:0] i_angle_measured;
    logic signed [DATA_W-1:0] i_speed_target;
    logic signed [DATA_W-1:0] i_speed_measured;
    logic signed [DATA_W-1:0] i_coriolis_torque;
    logic signed [DATA_W-1:0] i_prior_torque;
    logic [GAIN_W-1:0]        i_stiffness_in;
    logic [GAIN_W-1:0]        i_damping_in;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [JOINT_W-1:0]       o_joint_out;
    logic signed [DATA_W-1:0] o_torque_command;
    logic                     o_was_limited;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [GAIN_W-1:0]        i_cfg_data;

    // model state
    logic [ALPHA_W-1:0]       alpha_reg;
    logic [GAIN_W-1:0]        cor_gain_reg;
    logic [GAIN_W-1:0]        step_reg;
    logic signed [DATA_W-1:0] speed_lpf [NUM_JOINTS];
    logic [GAIN_W-1:0]        stiff_gain [NUM_JOINTS];
    logic [GAIN_W-1:0]        damp_gain [NUM_JOINTS];

    t_cmd torque_cmds_due [$];
    int   fault_count   = 0;
    int   cycle_count   = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   out_hold_left = 0;

    joint_impedance_torque_law_unit DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp_s32(input longint x);
        if (x > longint'(S_MAX)) begin
            return longint'(S_MAX);
        end
        if (x < longint'(S_MIN)) begin
            return longint'(S_MIN);
        end
        return x;
    endfunction

    function automatic void torque_law_step(input t_beat b);
        longint a, filt, e_q, e_v, tau, diff, lim, cmd, fin;
        t_cmd   c;
        if (b.joint >= NUM_JOINTS) begin
            return;
        end
        if (b.op == OP_LOAD) begin
            stiff_gain[b.joint] = b.stiffness;
            damp_gain[b.joint]  = b.damping;
            return;
        end
        a = (alpha_reg > ALPHA_ONE) ? 64'sd65536 : longint'(alpha_reg);
        filt = ((64'sd65536 - a) * longint'(speed_lpf[b.joint])
              + a * longint'(b.speed_measured)) >>> 16;
        filt = clamp_s32(filt);
        speed_lpf[b.joint] = filt[DATA_W-1:0];
        e_q = clamp_s32(longint'(b.angle_target) - longint'(b.angle_measured));
        e_v = clamp_s32(longint'(b.speed_target) - filt);
        tau = ((longint'(cor_gain_reg) * longint'(b.coriolis)) >>> FRAC)
            + ((longint'(stiff_gain[b.joint]) * e_q) >>> FRAC)
            + ((longint'(damp_gain[b.joint]) * e_v) >>> FRAC);
        lim = longint'(step_reg);
        diff = tau - longint'(b.prior);
        c.limited = 1'b0;
        if (diff > lim) begin
            diff = lim;
            c.limited = 1'b1;
        end else if (diff < -lim) begin
            diff = -lim;
            c.limited = 1'b1;
        end
        cmd = longint'(b.prior) + diff;
        fin = clamp_s32(cmd);
        if (fin != cmd) begin
            c.limited = 1'b1;
        end
        c.joint  = b.joint;
        c.torque = fin[DATA_W-1:0];
        torque_cmds_due = {torque_cmds_due, c};
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(9))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            8, 9: return $urandom;
            default: return $signed($urandom_range(0, 2**19)) - 2**18;
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(9))
            0: return '0;
            1: return G_MAX;
            7, 8: return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, 2**18));
        endcase
    endfunction

    function automatic t_beat make_control(input logic [JOINT_W-1:0] j,
                                           input logic signed [DATA_W-1:0] qt, qm, vt, vm,
                                           input logic signed [DATA_W-1:0] cor, prior);
        t_beat b;
        b.op = OP_CONTROL;
        b.joint = j;
        b.angle_target = qt;
        b.angle_measured = qm;
        b.speed_target = vt;
        b.speed_measured = vm;
        b.coriolis = cor;
        b.prior = prior;
        b.stiffness = GAIN_W'($urandom);
        b.damping = GAIN_W'($urandom);
        return b;
    endfunction

    function automatic t_beat make_load(input logic [JOINT_W-1:0] j,
                                        input logic [GAIN_W-1:0] k, d);
        t_beat b;
        b = make_control(j, rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word());
        b.op = OP_LOAD;
        b.stiffness = k;
        b.damping = d;
        return b;
    endfunction

    function automatic t_beat rand_beat();
        t_beat b;
        b = make_control(JOINT_W'($urandom_range(0, NUM_JOINTS - 1)), rand_word(),
                         rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        if ($urandom_range(99) < 5) begin
            b.joint = 3'd7;
        end
        if ($urandom_range(99) < 15) begin
            b.op = OP_LOAD;
            b.stiffness = rand_gain();
            b.damping = rand_gain();
        end
        return b;
    endfunction

    // valid stays high after an accepted beat; settle_block lowers it, the next call only while it idles
    task automatic offer_beat(input t_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_operation       <= b.op;
        i_joint           <= b.joint;
        i_angle_target    <= b.angle_target;
        i_angle_measured  <= b.angle_measured;
        i_speed_target    <= b.speed_target;
        i_speed_measured  <= b.speed_measured;
        i_coriolis_torque <= b.coriolis;
        i_prior_torque    <= b.prior;
        i_stiffness_in    <= b.stiffness;
        i_damping_in      <= b.damping;
        do @(posedge i_clk); while (o_in_stall);
        torque_law_step(b);
    endtask

    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (torque_cmds_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [GAIN_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FILTER_ALPHA:    alpha_reg = value[ALPHA_W-1:0];
            CFG_CORIOLIS_GAIN:   cor_gain_reg = value;
            CFG_MAX_TORQUE_STEP: step_reg = value;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_gain_loads();
        offer_beat(make_load(3'd0, G_MAX, G_MAX));
        offer_beat(make_load(3'd6, 31'd65536, 31'd32768));
        offer_beat(make_load(3'd7, G_MAX, G_MAX));
        offer_beat(make_load(3'd3, '0, '0));
    endtask

    task automatic test_field_extremes();
        offer_beat(make_control(3'd0, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX));
        offer_beat(make_control(3'd0, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN));
        offer_beat(make_control(3'd6, '0, '0, '0, '0, '0, '0));
        offer_beat(make_control(3'd6, 32'sd65536, -32'sd32768, 32'sd1000, -32'sd5000,
                                32'sd20000, 32'sd40000));
        offer_beat(make_control(3'd3, 32'sd9999, 32'sd1, -32'sd77, 32'sd300,
                                -32'sd123456, 32'sd70000));
        offer_beat(make_control(3'd7, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX));
    endtask

    task automatic test_filter_alpha_edges();
        settle_block();
        write_register(CFG_FILTER_ALPHA, 31'd131071);
        offer_beat(make_control(3'd6, '0, '0, '0, S_MAX, '0, '0));
        offer_beat(make_control(3'd6, 32'sd100, '0, S_MIN, S_MAX, '0, '0));
        settle_block();
        write_register(CFG_FILTER_ALPHA, '0);
        offer_beat(make_control(3'd6, '0, '0, '0, S_MIN, '0, '0));
        offer_beat(make_control(3'd6, '0, '0, S_MIN, S_MIN, '0, '0));
        settle_block();
        write_register(CFG_FILTER_ALPHA, 31'd65536);
        offer_beat(make_control(3'd6, '0, '0, 32'sd5, -32'sd65536, '0, '0));
    endtask

    task automatic test_step_and_saturation();
        settle_block();
        write_register(CFG_MAX_TORQUE_STEP, '0);
        offer_beat(make_control(3'd6, 32'sd65536, '0, '0, '0, 32'sd300, 32'sd7));
        settle_block();
        write_register(CFG_CORIOLIS_GAIN, G_MAX);
        write_register(CFG_MAX_TORQUE_STEP, G_MAX);
        offer_beat(make_control(3'd0, S_MAX, '0, '0, '0, S_MAX, S_MAX));
        offer_beat(make_control(3'd0, S_MIN, '0, '0, '0, S_MIN, S_MIN));
    endtask

    task automatic test_random_traffic(input int seg);
        int    issued;
        t_beat b;
        settle_block();
        case (seg)
            0: begin
                write_register(CFG_FILTER_ALPHA, {14'd0, ALPHA_RESET});
                write_register(CFG_CORIOLIS_GAIN, 31'd65536);
                write_register(CFG_MAX_TORQUE_STEP, 31'd1 << 20);
            end
            1: begin
                write_register(CFG_FILTER_ALPHA, '0);
                write_register(CFG_CORIOLIS_GAIN, G_MAX);
                write_register(CFG_MAX_TORQUE_STEP, G_MAX);
            end
            2: begin
                write_register(CFG_FILTER_ALPHA, 31'd65536);
                write_register(CFG_CORIOLIS_GAIN, '0);
                write_register(CFG_MAX_TORQUE_STEP, '0);
            end
            3: begin
                write_register(CFG_FILTER_ALPHA, 31'd131071);
                write_register(CFG_CORIOLIS_GAIN, rand_gain());
                write_register(CFG_MAX_TORQUE_STEP, GAIN_W'($urandom_range(0, 2**20)));
            end
            4: begin
                write_register(CFG_FILTER_ALPHA, GAIN_W'($urandom));
                write_register(CFG_CORIOLIS_GAIN, GAIN_W'($urandom));
                write_register(CFG_MAX_TORQUE_STEP, GAIN_W'($urandom));
            end
            default: begin
                write_register(CFG_FILTER_ALPHA, 31'd32768);
                write_register(CFG_CORIOLIS_GAIN, 31'd65536);
                write_register(CFG_MAX_TORQUE_STEP, G_MAX);
            end
        endcase
        case (seg / 2)
            0: begin
                send_idle_pct = 16;
                recv_idle_pct = 75;
            end
            1: begin
                send_idle_pct = 75;
                recv_idle_pct = 16;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
        issued = 0;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            offer_beat(make_load(j[JOINT_W-1:0], rand_gain(), rand_gain()));
            issued++;
        end
        while (issued < SEG_ITEMS) begin
            b = rand_beat();
            offer_beat(b);
            if (b.joint < NUM_JOINTS) begin
                issued++;
            end
        end
    endtask

    task automatic test_output_backpressure();
        settle_block();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        out_hold_left = 1500;
        repeat (12) begin
            offer_beat(make_control(JOINT_W'($urandom_range(0, NUM_JOINTS - 1)),
                                    rand_word(), rand_word(), rand_word(), rand_word(),
                                    rand_word(), rand_word()));
        end
    endtask

    // receiver stall, with the long hold-off counted here
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_hold_left > 0) begin
                i_out_stall <= 1'b1;
                out_hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        t_cmd c;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (torque_cmds_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected beat: joint %0d torque %0d limited %0b",
                                 o_joint_out, o_torque_command, o_was_limited);
                    end
                end else begin
                    c = torque_cmds_due.pop_front();
                    if (o_joint_out !== c.joint || o_torque_command !== c.torque
                            || o_was_limited !== c.limited) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display({"mismatch @%0d exp/act: joint %0d/%0d ",
                                      "torque %0d/%0d limited %0b/%0b"},
                                     cycle_count, c.joint, o_joint_out, c.torque,
                                     o_torque_command, c.limited, o_was_limited);
                        end
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_operation       <= OP_CONTROL;
        i_joint           <= '0;
        i_angle_target    <= '0;
        i_angle_measured  <= '0;
        i_speed_target    <= '0;
        i_speed_measured  <= '0;
        i_coriolis_torque <= '0;
        i_prior_torque    <= '0;
        i_stiffness_in    <= '0;
        i_damping_in      <= '0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= CFG_FILTER_ALPHA;
        i_cfg_data        <= '0;
        alpha_reg    = ALPHA_RESET;
        cor_gain_reg = CGAIN_RESET;
        step_reg     = STEP_RESET;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            speed_lpf[j]  = '0;
            stiff_gain[j] = '0;
            damp_gain[j]  = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_gain_loads();
        test_field_extremes();
        test_filter_alpha_edges();
        test_step_and_saturation();
        for (int s = 0; s < 6; s++) begin
            test_random_traffic(s);
        end
        test_output_backpressure();
        settle_block();

        if (fault_count == 0 && torque_cmds_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
src/jitl_pkg.sv
src/jitl_serial_mult.sv
src/jitl_joint_store.sv
src/joint_impedance_torque_law_unit.sv
verif/joint_impedance_torque_law_unit_tb.sv
